// ===== src/ams_pkg.sv =====
// Shared types and constants for the adjacency matrix store.
// No dependencies; imported by ams_ctrl, ams_dp and the top level.
`default_nettype none

package ams_pkg;

	localparam int MAX_NODES_DEF   = 16;
	localparam int WEIGHT_BITS_DEF = 32;

	// widths of the fixed item fields and of the node count register
	localparam int ACT_W   = 3;
	localparam int NODE_W  = 4;
	localparam int NCFG_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [NCFG_W-1:0] NODE_COUNT_RST = NCFG_W'(16);

	typedef enum logic [ACT_W-1:0] {
		ACT_READ         = 3'd0,
		ACT_WRITE        = 3'd1,
		ACT_INDEG        = 3'd2,
		ACT_OUTDEG       = 3'd3,
		ACT_EDGES        = 3'd4,
		ACT_FILL_OFFDIAG = 3'd5,
		ACT_CLEAR        = 3'd6,
		ACT_FILL_INDEX   = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_WRITE,
		ST_SCAN,
		ST_SCAN_END,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic ld_item;
		logic rd_item;
		logic wr_item;
		logic scan_start;
		logic scan_step;
		logic sweep_start;
		logic sweep_step;
		logic sweep_zero;
		logic res_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		action_t action;
		logic    oor;
		logic    scan_last;
		logic    sweep_last;
	} stat_t;

endpackage

`default_nettype wire

// ===== src/ams_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ams_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/ams_ctrl.sv =====
// Controller state machine: sequences item decode, scans, sweeps and result hand-off.
// Depends on ams_pkg.
`default_nettype none

module ams_ctrl import ams_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				// post-reset clearing pass
				cmd.sweep_step = 1'b1;
				cmd.sweep_zero = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.oor) begin
					state_d = ST_FINISH;
				end else begin
					unique case (stat.action)
						ACT_READ: begin
							cmd.rd_item = 1'b1;
							state_d     = ST_FINISH;
						end
						ACT_WRITE: begin
							cmd.rd_item = 1'b1;
							state_d     = ST_WRITE;
						end
						ACT_INDEG, ACT_OUTDEG: begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN;
						end
						ACT_EDGES: begin
							state_d = ST_FINISH;
						end
						ACT_FILL_OFFDIAG, ACT_CLEAR, ACT_FILL_INDEX: begin
							cmd.sweep_start = 1'b1;
							state_d         = ST_SWEEP;
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_WRITE: begin
				cmd.wr_item = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				// last read data is counted on this edge
				state_d = ST_FINISH;
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/ams_dp.sv =====
// Datapath: node count register, item registers, entry RAM, scan and sweep
// counters, nonzero counter and result register. Depends on ams_pkg and ams_ram.
`default_nettype none

module ams_dp import ams_pkg::*; #(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wen,
	input  wire logic        [NCFG_W-1:0] cfg_wdata,
	input  wire logic        [ACT_W-1:0]  action,
	input  wire logic        [NODE_W-1:0] row,
	input  wire logic        [NODE_W-1:0] col,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire cmd_t                     cmd,
	output stat_t                         stat,
	output logic signed      [DATA_W-1:0] result,
	output logic                          out_of_range
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int DEPTH  = MAX_NODES * MAX_NODES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int NB_W   = $clog2(MAX_NODES + 1);
	localparam int CMP_W  = (NB_W > NCFG_W) ? NB_W : NCFG_W;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(MAX_NODES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [CMP_W-1:0]  N_MAX     = CMP_W'(MAX_NODES);
	localparam logic [IDX_W-1:0]  LAST_COL  = IDX_W'(MAX_NODES - 1);

	// config and captured item
	logic [NCFG_W-1:0]      node_count_q;
	action_t                action_q;
	logic [IDX_W-1:0]       row_q, col_q;
	logic [WEIGHT_BITS-1:0] value_q;
	logic                   oor_q;

	// degree scan
	logic [ADDR_W-1:0] scan_addr_q;
	logic [IDX_W-1:0]  scan_i_q;
	logic              scan_vld_s1;
	logic [NB_W-1:0]   deg_q;

	// fill sweep
	logic [ADDR_W-1:0] sw_addr_q, sw_lin_q;
	logic [IDX_W-1:0]  sw_r_q, sw_c_q;

	logic [CNT_W-1:0]         nz_q;
	logic signed [DATA_W-1:0] result_q;
	logic                     oor_out_q;

	logic [CMP_W-1:0]       n_act, row_ext, col_ext;
	logic                   item_oor;
	logic [ADDR_W-1:0]      item_addr, scan_start_addr, scan_stride;
	logic                   sw_active;
	logic [DATA_W-1:0]      lin_ext;
	logic [WEIGHT_BITS-1:0] sw_w;
	logic                   ram_we, ram_re;
	logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;
	logic signed [DATA_W-1:0] res_d;

	// active node count, clamped to 1..MAX_NODES
	always_comb begin
		if (node_count_q == '0) begin
			n_act = CMP_W'(1);
		end else if (CMP_W'(node_count_q) > N_MAX) begin
			n_act = N_MAX;
		end else begin
			n_act = CMP_W'(node_count_q);
		end
	end

	assign row_ext = CMP_W'(row);
	assign col_ext = CMP_W'(col);

	always_comb begin
		unique case (action_t'(action))
			ACT_READ, ACT_WRITE:   item_oor = (row_ext >= n_act) || (col_ext >= n_act);
			ACT_INDEG, ACT_OUTDEG: item_oor = (row_ext >= n_act);
			default:               item_oor = 1'b0;
		endcase
	end

	assign item_addr = ADDR_W'(row_q) * STRIDE + ADDR_W'(col_q);

	// in-degree walks down a column, out-degree along a row
	assign scan_start_addr = (action_q == ACT_INDEG) ? ADDR_W'(row_q) : ADDR_W'(row_q) * STRIDE;
	assign scan_stride     = (action_q == ACT_INDEG) ? STRIDE : ADDR_W'(1);

	assign sw_active = (CMP_W'(sw_r_q) < n_act) && (CMP_W'(sw_c_q) < n_act);
	assign lin_ext   = DATA_W'(sw_lin_q);

	always_comb begin
		sw_w = '0;
		if (!cmd.sweep_zero && sw_active) begin
			unique case (action_q)
				ACT_FILL_OFFDIAG: sw_w = (sw_r_q != sw_c_q) ? value_q : '0;
				ACT_FILL_INDEX:   sw_w = lin_ext[WEIGHT_BITS-1:0];
				default:          sw_w = '0;
			endcase
		end
	end

	assign ram_we    = cmd.wr_item | cmd.sweep_step;
	assign ram_waddr = cmd.sweep_step ? sw_addr_q : item_addr;
	assign ram_wdata = cmd.sweep_step ? sw_w : value_q;
	assign ram_re    = cmd.rd_item | cmd.scan_step;
	assign ram_raddr = cmd.scan_step ? scan_addr_q : item_addr;

	ams_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_d = '0;
		if (!oor_q) begin
			unique case (action_q)
				ACT_READ:              res_d = DATA_W'($signed(ram_rdata));
				ACT_INDEG, ACT_OUTDEG: res_d = DATA_W'(deg_q);
				ACT_EDGES:             res_d = DATA_W'(nz_q);
				default:               res_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			scan_vld_s1  <= 1'b0;
			sw_addr_q    <= '0;
			sw_lin_q     <= '0;
			sw_r_q       <= '0;
			sw_c_q       <= '0;
			nz_q         <= '0;
		end else begin
			if (cfg_wen) begin
				node_count_q <= cfg_wdata;
			end
			scan_vld_s1 <= cmd.scan_step;
			if (cmd.sweep_start) begin
				sw_addr_q <= '0;
				sw_lin_q  <= '0;
				sw_r_q    <= '0;
				sw_c_q    <= '0;
				nz_q      <= '0;
			end else if (cmd.sweep_step) begin
				sw_addr_q <= sw_addr_q + ADDR_W'(1);
				if (sw_active) begin
					sw_lin_q <= sw_lin_q + ADDR_W'(1);
				end
				if (sw_c_q == LAST_COL) begin
					sw_c_q <= '0;
					sw_r_q <= sw_r_q + IDX_W'(1);
				end else begin
					sw_c_q <= sw_c_q + IDX_W'(1);
				end
				nz_q <= nz_q + CNT_W'(|sw_w);
			end else if (cmd.wr_item) begin
				// old entry sits on the read port from the previous cycle
				nz_q <= nz_q + CNT_W'(|value_q) - CNT_W'(|ram_rdata);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			action_q <= action_t'(action);
			row_q    <= row_ext[IDX_W-1:0];
			col_q    <= col_ext[IDX_W-1:0];
			value_q  <= value[WEIGHT_BITS-1:0];
			oor_q    <= item_oor;
		end
		if (cmd.scan_start) begin
			scan_addr_q <= scan_start_addr;
			scan_i_q    <= '0;
			deg_q       <= '0;
		end else begin
			if (cmd.scan_step) begin
				scan_addr_q <= scan_addr_q + scan_stride;
				scan_i_q    <= scan_i_q + IDX_W'(1);
			end
			if (scan_vld_s1) begin
				deg_q <= deg_q + NB_W'(|ram_rdata);
			end
		end
		if (cmd.res_load) begin
			result_q  <= res_d;
			oor_out_q <= oor_q;
		end
	end

	assign stat.action     = action_q;
	assign stat.oor        = oor_q;
	assign stat.scan_last  = (CMP_W'(scan_i_q) == (n_act - CMP_W'(1)));
	assign stat.sweep_last = (sw_addr_q == LAST_ADDR);

	assign result       = result_q;
	assign out_of_range = oor_out_q;

endmodule

`default_nettype wire

// ===== src/adjacency_matrix_store_top.sv =====
// Top level of the adjacency matrix store: controller plus datapath.
// Depends on ams_pkg, ams_ctrl, ams_dp (and ams_ram through ams_dp).
`default_nettype none

// Adjacency matrix store. Holds a MAX_NODES x MAX_NODES matrix of signed
// WEIGHT_BITS-bit edge weights (row-major, one RAM) and a running count of
// nonzero entries. node_count (cfg_wdata, written with cfg_wen) sets the
// active side n, clamped to 1..MAX_NODES; the user writes it while the block
// is idle, which the block itself does not enforce. Items arrive on a
// valid/ready channel; each gives exactly one result transfer on the output
// channel, which has its own register, so the next item can be taken while a
// result still waits. One item is worked at a time; a write is a
// read-modify-write of the entry to keep the nonzero count, a degree query
// does one RAM read per entry of the row or column, and a fill or clear sweeps
// every RAM word once through the single write port. After reset a clearing
// pass zeroes the RAM; in_ready stays low during it, while node_count writes
// are taken as usual. Change node_count only between items and follow it with
// a clear; until then the edge count still includes entries outside the new
// active square.
module adjacency_matrix_store_top import ams_pkg::*; #(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     cfg_wen,
	input  wire logic        [NCFG_W-1:0] cfg_wdata,
	// input channel
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic        [ACT_W-1:0]  action,
	input  wire logic        [NODE_W-1:0] row,
	input  wire logic        [NODE_W-1:0] col,
	input  wire logic signed [DATA_W-1:0] value,
	// output channel
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed      [DATA_W-1:0] result,
	output logic                          out_of_range
);

	cmd_t  cmd;
	stat_t stat;

	ams_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ams_dp #(
		.MAX_NODES  (MAX_NODES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.action      (action),
		.row         (row),
		.col         (col),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.result      (result),
		.out_of_range(out_of_range)
	);

	// one item in flight: ready drops right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a new result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// scan reads never share a cycle with sweep or item writes
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !(cmd.sweep_step || cmd.wr_item || cmd.rd_item))
		else $error("RAM port conflict");

	// output valid only rises after a result load
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.res_load))
		else $error("out_valid without result load");

endmodule

`default_nettype wire
